[rtl/mersenne_twister_prng_macros.svh]
// Assertion macros for the generator blocks.
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH
`ifndef SYNTHESIS
`define MTP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MTP_ASSERT_NOW(label, ante, cons)
`define MTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/mtp_pkg.sv]
// Shared constants, types and functions of the generator.
package mtp_pkg;
	localparam int unsigned N_WORDS = 624;
	localparam int unsigned M_OFFSET = 397;
	localparam int unsigned IDX_W = $clog2(N_WORDS);
	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] TEMPER_B = 32'd2636928640;
	localparam logic [31:0] TEMPER_C = 32'd4022730752;
	localparam logic [31:0] MATRIX_A = 32'h9908b0df;
	localparam logic [31:0] UPPER_MASK = 32'h80000000;
	localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
	localparam logic [31:0] SEED_RESET = 32'd5489;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);
	localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(N_WORDS - M_OFFSET);
	localparam logic [IDX_W-1:0] M_IDX = IDX_W'(M_OFFSET);

	typedef struct packed {
		logic        start;
		logic [31:0] seed;
	} seed_ctl_t;

	typedef struct packed {
		logic [31:0] word;
		logic        use_range;
		logic [31:0] lo;
		logic [31:0] hi;
	} draw_t;

	function automatic logic [31:0] twist_word(logic [31:0] cur, logic [31:0] nxt,
			logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MATRIX_A;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage

[rtl/mtp_state_core.sv]
// State memory, seeding sequencer and per-word twist with tempering.
`include "mersenne_twister_prng_macros.svh"
module mtp_state_core
	import mtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seed_ctl_t   seed_ctl,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        use_range,
	input  logic [31:0] lower_bound,
	input  logic [31:0] upper_bound,
	output logic        draw_valid,
	input  logic        draw_ready,
	output draw_t       draw
);
	typedef enum logic [2:0] {
		C_SEED0, C_SMUL, C_SADD, C_IDLE, C_READ, C_HOLD
	} cstate_t;

	cstate_t          st_q;
	logic [31:0]      mem [N_WORDS];
	logic [31:0]      rda_s1, rdb_s1;
	logic [31:0]      prev_q, prod_q, cache_q;
	logic [IDX_W-1:0] k_q, p_q;
	logic             use_s1;
	logic [31:0]      lo_s1, hi_s1;
	draw_t            draw_q;

	logic             accept, re, we;
	logic [IDX_W-1:0] wa, addr_a, addr_b, p_next;
	logic [31:0]      wd, tw, seed_word;

	assign in_ready   = ((st_q == C_IDLE) || (st_q == C_HOLD && draw_ready))
		&& !seed_ctl.start;
	assign accept     = in_valid && in_ready;
	assign draw_valid = (st_q == C_HOLD);
	assign draw       = draw_q;
	assign p_next     = (p_q == LAST_IDX) ? '0 : p_q + 1'b1;
	assign addr_a     = p_next;
	assign addr_b     = (p_q >= WRAP_IDX) ? p_q - WRAP_IDX : p_q + M_IDX;
	assign re         = accept;
	assign tw         = twist_word(cache_q, rda_s1, rdb_s1);
	assign seed_word  = prod_q + {{(32-IDX_W){1'b0}}, k_q};

	always_comb begin
		we = 1'b0;
		wa = p_q;
		wd = tw;
		unique case (st_q)
			C_SEED0: begin
				we = 1'b1;
				wa = '0;
				wd = seed_ctl.seed;
			end
			C_SADD: begin
				we = 1'b1;
				wa = k_q;
				wd = seed_word;
			end
			C_READ: we = 1'b1;
			default: we = 1'b0;
		endcase
		if (seed_ctl.start) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rda_s1 <= mem[addr_a];
			rdb_s1 <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_SEED0;
			k_q  <= '0;
			p_q  <= '0;
		end else if (seed_ctl.start) begin
			st_q <= C_SEED0;
		end else begin
			unique case (st_q)
				C_SEED0: begin
					prev_q  <= seed_ctl.seed;
					cache_q <= seed_ctl.seed;
					k_q     <= IDX_W'(1);
					p_q     <= '0;
					st_q    <= C_SMUL;
				end
				C_SMUL: begin
					prod_q <= INIT_MULT * (prev_q ^ (prev_q >> 30));
					st_q   <= C_SADD;
				end
				C_SADD: begin
					prev_q <= seed_word;
					k_q    <= k_q + 1'b1;
					st_q   <= (k_q == LAST_IDX) ? C_IDLE : C_SMUL;
				end
				C_IDLE: begin
					if (accept) begin
						st_q <= C_READ;
					end
				end
				C_READ: begin
					cache_q          <= rda_s1;
					p_q              <= p_next;
					draw_q.word      <= temper(tw);
					draw_q.use_range <= use_s1;
					draw_q.lo        <= lo_s1;
					draw_q.hi        <= hi_s1;
					st_q             <= C_HOLD;
				end
				C_HOLD: begin
					if (accept) begin
						st_q <= C_READ;
					end else if (draw_ready) begin
						st_q <= C_IDLE;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_s1 <= use_range;
			lo_s1  <= lower_bound;
			hi_s1  <= upper_bound;
		end
	end

	`MTP_ASSERT_NEXT(a_accept_reads, accept, st_q == C_READ)
	`MTP_ASSERT_NEXT(a_read_holds, st_q == C_READ && !seed_ctl.start, st_q == C_HOLD)
	`MTP_ASSERT_NOW(a_no_take_seeding, st_q == C_SMUL || st_q == C_SADD, !in_ready)
endmodule

[rtl/mtp_range_map.sv]
// Range mapping with a bit-serial remainder unit and the output register.
`include "mersenne_twister_prng_macros.svh"
module mtp_range_map
	import mtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        draw_valid,
	output logic        draw_ready,
	input  draw_t       draw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_value
);
	typedef enum logic [1:0] {R_IDLE, R_DIV, R_OUT} rstate_t;

	rstate_t     st_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q, span_q, lo_q, out_q;
	logic [32:0] rem_q;

	logic        take, need_map;
	logic [32:0] rem_sh, rem_nx;

	assign draw_ready   = (st_q == R_IDLE) || (st_q == R_OUT && out_ready);
	assign take         = draw_valid && draw_ready;
	assign out_valid    = (st_q == R_OUT);
	assign random_value = out_q;
	assign need_map     = draw.use_range && (draw.lo <= draw.hi)
		&& ((draw.word < draw.lo) || (draw.word > draw.hi));
	assign rem_sh       = {rem_q[31:0], dvd_q[31]};
	assign rem_nx       = (rem_sh >= {1'b0, span_q}) ? rem_sh - {1'b0, span_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= R_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				R_IDLE, R_OUT: begin
					if (take) begin
						if (need_map) begin
							dvd_q  <= draw.word;
							span_q <= draw.hi - draw.lo + 32'd1;
							lo_q   <= draw.lo;
							rem_q  <= '0;
							cnt_q  <= '0;
							st_q   <= R_DIV;
						end else begin
							out_q <= draw.word;
							st_q  <= R_OUT;
						end
					end else if (st_q == R_OUT && out_ready) begin
						st_q <= R_IDLE;
					end
				end
				R_DIV: begin
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						out_q <= lo_q + rem_nx[31:0];
						st_q  <= R_OUT;
					end
				end
				default: st_q <= R_IDLE;
			endcase
		end
	end

	`MTP_ASSERT_NOW(a_rem_below_span, st_q == R_DIV, rem_q < {1'b0, span_q})
	`MTP_ASSERT_NEXT(a_map_starts, take && need_map, st_q == R_DIV && cnt_q == 5'd0)
	`MTP_ASSERT_NEXT(a_div_ends, st_q == R_DIV && cnt_q == 5'd31, st_q == R_OUT)
endmodule

[rtl/mersenne_twister_prng.sv]
// Top level of the MT19937 generator: register port and block wiring.
// Requests enter on in_valid/in_ready with use_range, lower_bound and
// upper_bound; each transaction returns one word on out_valid/out_ready.
// Every request twists one state word in place (memory read of two
// words, the third from a register, write-back of one) and tempers it
// into the hold register; a new request can be taken as the held word leaves.
// A word that needs range mapping goes through a one-bit-per-cycle
// remainder unit before it reaches the output register.
// After reset, and after each write of the seed register (byte address 0),
// the 624-word state is refilled by the seeding recurrence, during which
// no request is taken.
// Register writes are accepted always.
// A stalled receiver holds the result in the output register; one more
// request may then be in flight before in_ready drops.
module mersenne_twister_prng
	import mtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        use_range,
	input  logic [31:0] lower_bound,
	input  logic [31:0] upper_bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_value
);
	logic [31:0] seed_q;
	logic        start_q;
	seed_ctl_t   seed_ctl;
	logic        draw_valid, draw_ready;
	draw_t       draw;

	assign pready         = 1'b1;
	assign prdata         = paddr[2] ? 32'd0 : seed_q;
	assign seed_ctl.start = start_q;
	assign seed_ctl.seed  = seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= SEED_RESET;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (psel && penable && pwrite && pready && !paddr[2]) begin
				seed_q  <= pwdata;
				start_q <= 1'b1;
			end
		end
	end

	mtp_state_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_ctl   (seed_ctl),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.use_range  (use_range),
		.lower_bound(lower_bound),
		.upper_bound(upper_bound),
		.draw_valid (draw_valid),
		.draw_ready (draw_ready),
		.draw       (draw)
	);

	mtp_range_map u_range (
		.clk         (clk),
		.arst_n      (arst_n),
		.draw_valid  (draw_valid),
		.draw_ready  (draw_ready),
		.draw        (draw),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_value(random_value)
	);
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the MT19937 generator with range mapping.
module tb_top;
	import mtp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        use_range;
		logic [31:0] lower_bound;
		logic [31:0] upper_bound;
	} draw_req_t;

	localparam logic [2:0] SEED_ADDR = 3'd0;
	localparam int unsigned IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        use_range = 1'b0;
	logic [31:0] lower_bound = '0;
	logic [31:0] upper_bound = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] random_value;

	draw_req_t   pending_draws[$];
	logic [31:0] expected_words[$];
	logic [31:0] mt_words[N_WORDS];
	int unsigned mt_pos;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_phase = 0;
	int unsigned idle_cycles = 0;
	int unsigned errors = 0;
	bit          stimulus_done = 1'b0;
	bit          stall_enable = 1'b1;

	mersenne_twister_prng DUT (.*);

	always #5 clk = ~clk;

	function automatic void reseed_model(logic [31:0] s);
		logic [31:0] p;
		mt_words[0] = s;
		for (int k = 1; k < N_WORDS; k++) begin
			p = mt_words[k-1];
			mt_words[k] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(k);
		end
		mt_pos = N_WORDS;
	endfunction

	function automatic logic [31:0] draw_word(draw_req_t r);
		logic [31:0] y;
		logic [31:0] v;
		logic [63:0] span;
		if (mt_pos >= N_WORDS) begin
			for (int k = 0; k < N_WORDS; k++) begin
				y = (mt_words[k] & 32'h80000000)
					| (mt_words[(k+1) % N_WORDS] & 32'h7fffffff);
				v = mt_words[(k+397) % N_WORDS] ^ (y >> 1);
				if (y[0]) begin
					v = v ^ 32'h9908b0df;
				end
				mt_words[k] = v;
			end
			mt_pos = 0;
		end
		y = mt_words[mt_pos];
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'd2636928640);
		y = y ^ ((y << 15) & 32'd4022730752);
		y = y ^ (y >> 18);
		mt_pos = mt_pos + 1;
		if (r.use_range && r.lower_bound <= r.upper_bound
				&& (y < r.lower_bound || y > r.upper_bound)) begin
			span = {32'd0, r.upper_bound} - {32'd0, r.lower_bound} + 64'd1;
			y = r.lower_bound + 32'({32'd0, y} % span);
		end
		return y;
	endfunction

	task automatic write_seed(logic [31:0] s);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= s;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reseed_model(s);
	endtask

	task automatic wait_drained();
		while (pending_draws.size() != 0 || in_valid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
	endtask

	function automatic draw_req_t rand_draw();
		draw_req_t r;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		r.use_range = $urandom_range(0, 3) != 0;
		r.lower_bound = $urandom;
		r.upper_bound = $urandom;
		case (sel)
			0, 1, 2: begin
				r.upper_bound = r.lower_bound + $urandom_range(0, 1000);
				if (r.upper_bound < r.lower_bound) begin
					r.upper_bound = 32'hffffffff;
				end
			end
			3: r.upper_bound = r.lower_bound;
			4: begin
				r.lower_bound = 32'd0;
				r.upper_bound = 32'hffffffff;
			end
			5: begin
				r.lower_bound = $urandom_range(0, 255);
				r.upper_bound = r.lower_bound + $urandom_range(0, 255);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_draws(int unsigned count);
		repeat (count) pending_draws.push_back(rand_draw());
	endtask

	task automatic queue_draw(logic ur, logic [31:0] lo, logic [31:0] hi);
		draw_req_t r;
		r.use_range = ur;
		r.lower_bound = lo;
		r.upper_bound = hi;
		pending_draws.push_back(r);
	endtask

	initial begin
		reseed_model(SEED_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		queue_draw(1'b0, 32'd0, 32'd0);
		queue_draw(1'b0, 32'hffffffff, 32'hffffffff);
		queue_draw(1'b1, 32'd0, 32'hffffffff);
		queue_draw(1'b1, 32'd0, 32'd0);
		queue_draw(1'b1, 32'hffffffff, 32'hffffffff);
		queue_draw(1'b1, 32'hffffffff, 32'd0);
		queue_draw(1'b1, 32'd10, 32'd5);
		queue_draw(1'b1, 32'd0, 32'd1);
		queue_draw(1'b1, 32'd100, 32'd199);
		queue_draw(1'b1, 32'h80000000, 32'hffffffff);
		queue_draw(1'b1, 32'd1, 32'hfffffffe);
		queue_draw(1'b1, 32'h55555555, 32'haaaaaaaa);
		queue_draw(1'b1, 32'haaaaaaaa, 32'h55555555);
		queue_draw(1'b1, 32'd0, 32'h7fffffff);
		wait_drained();
		write_seed(32'd0);
		queue_draws(250);
		wait_drained();
		write_seed(32'hffffffff);
		queue_draws(80);
		wait_drained();
		write_seed($urandom);
		queue_draws(640);
		wait_drained();
		stimulus_done = 1'b1;
	end

	always @(posedge clk) begin
		draw_req_t r;
		if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_words.push_back(draw_word('{use_range, lower_bound, upper_bound}));
			end
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_draws.size() != 0) begin
				r = pending_draws.pop_front();
				in_valid <= 1'b1;
				use_range <= r.use_range;
				lower_bound <= r.lower_bound;
				upper_bound <= r.upper_bound;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 512 == 0) begin
			stall_enable <= $urandom_range(0, 2) != 0;
		end
		out_ready <= !stall_enable || ((stall_phase % 7) < 4) || $urandom_range(0, 3) == 0;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("random_value: unexpected transaction, actual %h", random_value);
				errors <= errors + 1;
			end else if (expected_words[0] !== random_value) begin
				$error("random_value: expected %h actual %h", expected_words[0], random_value);
				errors <= errors + 1;
				void'(expected_words.pop_front());
			end else begin
				void'(expected_words.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (stimulus_done) begin
			if (errors == 0 && expected_words.size() == 0) begin
				$display("tb_top passed");
			end else begin
				$display("tb_top failed");
			end
			$finish;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end
endmodule
